// File: hw/rtl/intensity_bug_mode_controller_top_assert.svh
// Assertion macros for the intensity bug mode controller checker.
// No dependencies; the user supplies clk and rst in scope.
`ifndef INTENSITY_BUG_MODE_CONTROLLER_TOP_ASSERT_SVH
`define INTENSITY_BUG_MODE_CONTROLLER_TOP_ASSERT_SVH

// check prop in the same cycle as cond
`define IBMC_ASSERT_NOW(name, cond, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// check prop in the cycle after cond
`define IBMC_ASSERT_NEXT(name, cond, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

// File: hw/rtl/ibmc_pkg.sv
// Shared types and constants for the intensity bug mode controller.
// No dependencies.
`timescale 1ns / 1ps

package ibmc_pkg;

  localparam int WINDOW_DEF = 30;
  localparam int GROUP_LEN  = 4;
  localparam int IR_COUNT   = 12;
  localparam int IR_PER_GRP = 4;
  localparam int IR_IDX_W   = 4;
  localparam int CFG_W      = 19;
  localparam int CFG_IDX_W  = 2;

  typedef logic [1:0] mode_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam mode_t MODE_FOLLOW   = 2'd0;
  localparam mode_t MODE_ROTATE   = 2'd1;
  localparam mode_t MODE_APPROACH = 2'd2;

  localparam cfg_idx_t REG_OBSTACLE_LIMIT = 2'd0;
  localparam cfg_idx_t REG_PEAK_MARGIN    = 2'd1;
  localparam cfg_idx_t REG_FACING_INDEX   = 2'd2;

  localparam logic [15:0] OBSTACLE_LIMIT_RST = 16'd200;
  localparam logic [18:0] PEAK_MARGIN_RST    = 19'd8;
  localparam logic [3:0]  FACING_INDEX_RST   = 4'd9;

endpackage

// File: hw/rtl/intensity_bug_mode_controller_top.sv
// Intensity bug mode controller: window peak detect, hit/leave state, mode select.
// Depends on ibmc_pkg.
`timescale 1ns / 1ps

// One beat per cycle is taken on the input channel when the output side does
// not stall; its result beat is presented after four register stages, the
// first loaded at the accepting edge: the sample window shift with group
// partial sums, min/max and infrared group maxima; the third sums and the
// facing match; the trimmed sums; and the output register, where the peak
// compare and the follow/hit level state are updated.
// Throughput is one beat per cycle and follows out_ready only; a stalled
// stage holds, and empty stages ahead of it keep taking beats.
module intensity_bug_mode_controller_top #(
  parameter int WINDOW = ibmc_pkg::WINDOW_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  ibmc_pkg::cfg_idx_t          cfg_index,
  input  logic [ibmc_pkg::CFG_W-1:0]  cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [15:0]                 light_sample,
  input  logic [15:0]                 range_front,
  input  logic [15:0]                 range_front_left,
  input  logic [15:0]                 range_front_right,
  input  logic [63:0]                 ir_group_low,
  input  logic [63:0]                 ir_group_mid,
  input  logic [63:0]                 ir_group_high,
  output logic                        out_valid,
  input  logic                        out_ready,
  output ibmc_pkg::mode_t             mode,
  output logic                        peak_seen,
  output logic                        left_boundary,
  output logic                        hit_obstacle
);

  localparam int GRP     = ibmc_pkg::GROUP_LEN;
  localparam int THIRD   = WINDOW / 3;
  localparam int NEW_LEN = WINDOW - 2 * THIRD;
  localparam int NG      = (NEW_LEN + GRP - 1) / GRP;
  localparam int GSUM_W  = 16 + $clog2(GRP);
  localparam int SUM_W   = 16 + $clog2(NEW_LEN);
  localparam int CMP_W   = ((SUM_W > ibmc_pkg::CFG_W) ? SUM_W : ibmc_pkg::CFG_W) + 1;
  localparam int EXT     = WINDOW + GRP;
  localparam int NIR     = ibmc_pkg::IR_COUNT / ibmc_pkg::IR_PER_GRP;
  localparam int IW      = ibmc_pkg::IR_IDX_W;

  logic [15:0] obstacle_limit;
  logic [18:0] peak_margin;
  logic [3:0]  facing_index;

  logic [15:0] window  [WINDOW];
  logic [15:0] win_ext [EXT];

  logic a_valid, b_valid, c_valid;
  logic a_ready, b_ready, c_ready, d_ready;
  logic accept, a_adv, b_adv, c_adv;

  // stage A
  logic [GSUM_W-1:0] gsum [3][NG];
  logic [15:0]       gmin [3][NG];
  logic [15:0]       gmax [3][NG];
  logic [15:0]       irv  [NIR];
  logic [IW-1:0]     iri  [NIR];
  logic              blocked;

  logic [GSUM_W-1:0] a_gsum [3][NG];
  logic [15:0]       a_gmin [3][NG];
  logic [15:0]       a_gmax [3][NG];
  logic [15:0]       a_irv  [NIR];
  logic [IW-1:0]     a_iri  [NIR];
  logic [15:0]       a_sample;
  logic              a_blocked;

  // stage B
  logic [SUM_W-1:0] tsum [3];
  logic [15:0]      tmin [3];
  logic [15:0]      tmax [3];
  logic             approach;

  logic [SUM_W-1:0] b_sum [3];
  logic [15:0]      b_lo  [3];
  logic [15:0]      b_hi  [3];
  logic [15:0]      b_sample;
  logic             b_blocked;
  logic             b_approach;

  // stage C
  logic [SUM_W-1:0] c_trim [3];
  logic [15:0]      c_sample;
  logic             c_blocked;
  logic             c_approach;

  // output stage and state
  logic        following;
  logic [15:0] hit_level;
  logic        peak;
  logic        leave;
  logic        hit;
  logic        following_next;
  logic [CMP_W-1:0] mid_ext, old_lim, new_lim;

  // handshake chain
  assign d_ready  = !out_valid || out_ready;
  assign c_ready  = !c_valid || d_ready;
  assign b_ready  = !b_valid || c_ready;
  assign a_ready  = !a_valid || b_ready;
  assign in_ready = a_ready;
  assign accept   = in_valid && in_ready;
  assign a_adv    = a_valid && b_ready;
  assign b_adv    = b_valid && c_ready;
  assign c_adv    = c_valid && d_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      c_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      a_valid   <= accept || (a_valid && !b_ready);
      b_valid   <= a_adv || (b_valid && !c_ready);
      c_valid   <= b_adv || (c_valid && !d_ready);
      out_valid <= c_adv || (out_valid && !out_ready);
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      obstacle_limit <= ibmc_pkg::OBSTACLE_LIMIT_RST;
      peak_margin    <= ibmc_pkg::PEAK_MARGIN_RST;
      facing_index   <= ibmc_pkg::FACING_INDEX_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        ibmc_pkg::REG_OBSTACLE_LIMIT: obstacle_limit <= cfg_wdata[15:0];
        ibmc_pkg::REG_PEAK_MARGIN:    peak_margin    <= cfg_wdata[18:0];
        ibmc_pkg::REG_FACING_INDEX:   facing_index   <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  // shifted window view, oldest at index 0, padded past the end
  always_comb begin
    for (int i = 0; i < EXT; i++) begin
      if (i < WINDOW - 1) begin
        win_ext[i] = window[i+1];
      end else if (i == WINDOW - 1) begin
        win_ext[i] = light_sample;
      end else begin
        win_ext[i] = 16'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WINDOW; i++) window[i] <= 16'd0;
    end else if (accept) begin
      for (int i = 0; i < WINDOW; i++) window[i] <= win_ext[i];
    end
  end

  // group partials per third
  always_comb begin
    for (int t = 0; t < 3; t++) begin
      for (int g = 0; g < NG; g++) begin
        gsum[t][g] = '0;
        gmin[t][g] = 16'hFFFF;
        gmax[t][g] = 16'd0;
        for (int e = 0; e < GRP; e++) begin
          if (g * GRP + e < ((t == 2) ? NEW_LEN : THIRD)) begin
            gsum[t][g] = gsum[t][g] + GSUM_W'(win_ext[t * THIRD + g * GRP + e]);
            if (win_ext[t * THIRD + g * GRP + e] < gmin[t][g])
              gmin[t][g] = win_ext[t * THIRD + g * GRP + e];
            if (win_ext[t * THIRD + g * GRP + e] > gmax[t][g])
              gmax[t][g] = win_ext[t * THIRD + g * GRP + e];
          end
        end
      end
    end
  end

  // first maximum within each infrared group
  always_comb begin
    logic [63:0] grp;
    grp = ir_group_low;
    for (int k = 0; k < NIR; k++) begin
      case (k)
        0:       grp = ir_group_low;
        1:       grp = ir_group_mid;
        default: grp = ir_group_high;
      endcase
      irv[k] = grp[15:0];
      iri[k] = IW'(k * ibmc_pkg::IR_PER_GRP);
      for (int e = 1; e < ibmc_pkg::IR_PER_GRP; e++) begin
        if (grp[16*e +: 16] > irv[k]) begin
          irv[k] = grp[16*e +: 16];
          iri[k] = IW'(k * ibmc_pkg::IR_PER_GRP + e);
        end
      end
    end
  end

  always_comb begin
    logic [15:0] nearest;
    nearest = range_front;
    if (range_front_left < nearest) nearest = range_front_left;
    if (range_front_right < nearest) nearest = range_front_right;
    blocked = nearest < obstacle_limit;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_gsum    <= gsum;
      a_gmin    <= gmin;
      a_gmax    <= gmax;
      a_irv     <= irv;
      a_iri     <= iri;
      a_sample  <= light_sample;
      a_blocked <= blocked;
    end
  end

  // third sums and facing match
  always_comb begin
    logic [15:0]   best_v;
    logic [IW-1:0] best_i;
    for (int t = 0; t < 3; t++) begin
      tsum[t] = '0;
      tmin[t] = 16'hFFFF;
      tmax[t] = 16'd0;
      for (int g = 0; g < NG; g++) begin
        tsum[t] = tsum[t] + SUM_W'(a_gsum[t][g]);
        if (a_gmin[t][g] < tmin[t]) tmin[t] = a_gmin[t][g];
        if (a_gmax[t][g] > tmax[t]) tmax[t] = a_gmax[t][g];
      end
    end
    best_v = a_irv[0];
    best_i = a_iri[0];
    for (int k = 1; k < NIR; k++) begin
      if (a_irv[k] > best_v) begin
        best_v = a_irv[k];
        best_i = a_iri[k];
      end
    end
    approach = best_i == facing_index;
  end

  always_ff @(posedge clk) begin
    if (a_adv) begin
      b_sum      <= tsum;
      b_lo       <= tmin;
      b_hi       <= tmax;
      b_sample   <= a_sample;
      b_blocked  <= a_blocked;
      b_approach <= approach;
    end
  end

  always_ff @(posedge clk) begin
    if (b_adv) begin
      for (int t = 0; t < 3; t++) begin
        c_trim[t] <= b_sum[t] - (SUM_W'(b_lo[t]) + SUM_W'(b_hi[t]));
      end
      c_sample   <= b_sample;
      c_blocked  <= b_blocked;
      c_approach <= b_approach;
    end
  end

  // peak compare and hit/leave decision
  assign mid_ext = CMP_W'(c_trim[1]);
  assign old_lim = CMP_W'(c_trim[0]) + CMP_W'(peak_margin);
  assign new_lim = CMP_W'(c_trim[2]) + CMP_W'(peak_margin);
  assign peak    = (mid_ext > old_lim) && (mid_ext > new_lim);
  assign leave   = following && peak && (c_sample > hit_level);
  assign hit     = !following && c_blocked;

  always_comb begin
    following_next = following;
    if (leave) begin
      following_next = 1'b0;
    end else if (hit) begin
      following_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      following <= 1'b0;
      hit_level <= 16'd0;
    end else if (c_adv) begin
      following <= following_next;
      if (!leave && hit) begin
        hit_level <= c_sample;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (c_adv) begin
      if (following_next) begin
        mode <= ibmc_pkg::MODE_FOLLOW;
      end else if (c_approach) begin
        mode <= ibmc_pkg::MODE_APPROACH;
      end else begin
        mode <= ibmc_pkg::MODE_ROTATE;
      end
      peak_seen     <= peak;
      left_boundary <= leave;
      hit_obstacle  <= !leave && hit;
    end
  end

endmodule

// File: hw/rtl/ibmc_checker.sv
// Port-level checks for the intensity bug mode controller, bound to the top.
// Depends on ibmc_pkg and intensity_bug_mode_controller_top_assert.svh.
`timescale 1ns / 1ps
`include "intensity_bug_mode_controller_top_assert.svh"

module ibmc_checker (
  input logic            clk,
  input logic            rst,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input ibmc_pkg::mode_t mode,
  input logic            peak_seen,
  input logic            left_boundary,
  input logic            hit_obstacle
);

  `IBMC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable({mode, peak_seen, left_boundary, hit_obstacle}), "stalled result beat changed")
  `IBMC_ASSERT_NOW(a_hit_follows, out_valid && hit_obstacle, mode == ibmc_pkg::MODE_FOLLOW && !left_boundary, "hit beat not in follow mode")
  `IBMC_ASSERT_NOW(a_leave_peak, out_valid && left_boundary, peak_seen && mode != ibmc_pkg::MODE_FOLLOW, "leave without peak or still following")
  `IBMC_ASSERT_NOW(a_empty_ready, !out_valid, in_ready, "input stalled with empty output")

endmodule

bind intensity_bug_mode_controller_top ibmc_checker u_ibmc_checker (.*);

// File: sim/tb_intensity_bug_mode_controller_top.sv
// Self-checking testbench for intensity_bug_mode_controller_top: window peaks, hit/leave, mode.
// Depends on ibmc_pkg and the block's RTL; a built-in predictor checks every result beat.
`timescale 1ns / 1ps

module tb_intensity_bug_mode_controller_top;

  localparam int LIGHT_DEPTH = ibmc_pkg::WINDOW_DEF;
  localparam ibmc_pkg::cfg_idx_t REG_UNUSED_SLOT = 2'd3;

  typedef struct packed {
    logic [15:0] light;
    logic [15:0] front;
    logic [15:0] front_left;
    logic [15:0] front_right;
    logic [63:0] ir_low;
    logic [63:0] ir_mid;
    logic [63:0] ir_high;
  } sensor_tick_t;

  typedef struct packed {
    ibmc_pkg::mode_t mode;
    logic            peak;
    logic            left;
    logic            hit;
  } tick_result_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_wr_en;
  ibmc_pkg::cfg_idx_t cfg_index;
  logic [ibmc_pkg::CFG_W-1:0] cfg_wdata;
  logic in_valid;
  logic in_ready;
  logic [15:0] light_sample;
  logic [15:0] range_front;
  logic [15:0] range_front_left;
  logic [15:0] range_front_right;
  logic [63:0] ir_group_low;
  logic [63:0] ir_group_mid;
  logic [63:0] ir_group_high;
  logic out_valid;
  logic out_ready;
  ibmc_pkg::mode_t mode;
  logic peak_seen;
  logic left_boundary;
  logic hit_obstacle;

  logic [15:0] light_history [LIGHT_DEPTH];
  logic        tracking_boundary;
  logic [15:0] stored_hit_level;
  logic [15:0] obstacle_limit_q;
  logic [18:0] peak_margin_q;
  logic [3:0]  facing_index_q;

  tick_result_t pending_results[$];
  tick_result_t due_result;
  bit quiet_tail;
  int error_count;
  int ticks_sent;
  int results_checked;
  int hits_predicted;
  int leaves_predicted;
  int peaks_predicted;
  int settings_used;

  intensity_bug_mode_controller_top dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .light_sample     (light_sample),
    .range_front      (range_front),
    .range_front_left (range_front_left),
    .range_front_right(range_front_right),
    .ir_group_low     (ir_group_low),
    .ir_group_mid     (ir_group_mid),
    .ir_group_high    (ir_group_high),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .mode             (mode),
    .peak_seen        (peak_seen),
    .left_boundary    (left_boundary),
    .hit_obstacle     (hit_obstacle)
  );

  always #5 clk = ~clk;

  function automatic longint trimmed_third(int from, int upto);
    longint total;
    int unsigned lo, hi;
    total = 0;
    lo = 16'hFFFF;
    hi = 0;
    for (int i = from; i < upto; i++) begin
      total += light_history[i];
      if (light_history[i] < lo) lo = light_history[i];
      if (light_history[i] > hi) hi = light_history[i];
    end
    return total - lo - hi;
  endfunction

  function automatic tick_result_t predict_tick(sensor_tick_t t);
    tick_result_t r;
    longint old_sum, mid_sum, new_sum, margin;
    logic [15:0] nearest, best_val;
    logic [191:0] readings;
    int third, best_pos;
    third = LIGHT_DEPTH / 3;
    for (int i = 0; i < LIGHT_DEPTH - 1; i++) light_history[i] = light_history[i + 1];
    light_history[LIGHT_DEPTH - 1] = t.light;
    old_sum = trimmed_third(0, third);
    mid_sum = trimmed_third(third, 2 * third);
    new_sum = trimmed_third(2 * third, LIGHT_DEPTH);
    margin = peak_margin_q;
    r.peak = (mid_sum - old_sum > margin) && (mid_sum - new_sum > margin);
    nearest = t.front;
    if (t.front_left < nearest) nearest = t.front_left;
    if (t.front_right < nearest) nearest = t.front_right;
    r.left = 1'b0;
    r.hit = 1'b0;
    if (tracking_boundary && r.peak && t.light > stored_hit_level) begin
      tracking_boundary = 1'b0;
      r.left = 1'b1;
    end else if (!tracking_boundary && nearest < obstacle_limit_q) begin
      tracking_boundary = 1'b1;
      stored_hit_level = t.light;
      r.hit = 1'b1;
    end
    if (tracking_boundary) begin
      r.mode = ibmc_pkg::MODE_FOLLOW;
    end else begin
      readings = {t.ir_high, t.ir_mid, t.ir_low};
      best_pos = 0;
      best_val = readings[15:0];
      for (int i = 1; i < ibmc_pkg::IR_COUNT; i++) begin
        if (readings[16*i +: 16] > best_val) begin
          best_val = readings[16*i +: 16];
          best_pos = i;
        end
      end
      r.mode = (best_pos == facing_index_q) ? ibmc_pkg::MODE_APPROACH
                                            : ibmc_pkg::MODE_ROTATE;
    end
    hits_predicted += r.hit;
    leaves_predicted += r.left;
    peaks_predicted += r.peak;
    return r;
  endfunction

  function automatic logic [191:0] ir_pattern(int unsigned pos, logic [15:0] top,
                                              logic [15:0] rest_max);
    logic [191:0] readings;
    for (int i = 0; i < ibmc_pkg::IR_COUNT; i++)
      readings[16*i +: 16] = 16'($urandom_range(0, rest_max));
    readings[16*pos +: 16] = top;
    return readings;
  endfunction

  function automatic sensor_tick_t make_tick(logic [15:0] light, logic [15:0] front,
                                             logic [15:0] front_left, logic [15:0] front_right,
                                             logic [191:0] readings);
    sensor_tick_t t;
    t.light = light;
    t.front = front;
    t.front_left = front_left;
    t.front_right = front_right;
    {t.ir_high, t.ir_mid, t.ir_low} = readings;
    return t;
  endfunction

  function automatic sensor_tick_t random_tick(bit blocked);
    sensor_tick_t t;
    logic [191:0] readings;
    logic [15:0] top;
    int unsigned lim, pos, twin;
    lim = obstacle_limit_q;
    t.light = 16'($urandom_range(0, 65535));
    if (blocked && lim > 0) begin
      t.front = 16'($urandom_range(0, 65535));
      t.front_left = 16'($urandom_range(0, 65535));
      t.front_right = 16'($urandom_range(0, 65535));
      case ($urandom_range(0, 2))
        0: t.front = 16'($urandom_range(0, lim - 1));
        1: t.front_left = 16'($urandom_range(0, lim - 1));
        default: t.front_right = 16'($urandom_range(0, lim - 1));
      endcase
    end else if ($urandom_range(0, 3) != 0) begin
      t.front = 16'($urandom_range(lim, 65535));
      t.front_left = 16'($urandom_range(lim, 65535));
      t.front_right = 16'($urandom_range(lim, 65535));
    end else begin
      t.front = 16'($urandom_range(0, 65535));
      t.front_left = 16'($urandom_range(0, 65535));
      t.front_right = 16'($urandom_range(0, 65535));
    end
    if (facing_index_q < ibmc_pkg::IR_COUNT && $urandom_range(0, 1) == 1) pos = facing_index_q;
    else pos = $urandom_range(0, ibmc_pkg::IR_COUNT - 1);
    top = 16'($urandom_range(1, 65535));
    case ($urandom_range(0, 3))
      0: readings = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      1: readings = ir_pattern(pos, top, top - 16'd1);
      2: begin
        readings = ir_pattern(pos, top, top - 16'd1);
        twin = $urandom_range(0, ibmc_pkg::IR_COUNT - 1);
        readings[16*twin +: 16] = top;
      end
      default: readings = {12{top}};
    endcase
    {t.ir_high, t.ir_mid, t.ir_low} = readings;
    return t;
  endfunction

  task automatic check_field(string what, logic [1:0] want, logic [1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      error_count++;
    end
  endtask

  task automatic send_tick(sensor_tick_t t);
    int gap;
    gap = 0;
    if (!quiet_tail && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 13);
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    light_sample = t.light;
    range_front = t.front;
    range_front_left = t.front_left;
    range_front_right = t.front_right;
    ir_group_low = t.ir_low;
    ir_group_mid = t.ir_mid;
    ir_group_high = t.ir_high;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(predict_tick(t));
    ticks_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(ibmc_pkg::cfg_idx_t idx, logic [18:0] wdata);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_wdata = wdata;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    case (idx)
      ibmc_pkg::REG_OBSTACLE_LIMIT: obstacle_limit_q = wdata[15:0];
      ibmc_pkg::REG_PEAK_MARGIN:    peak_margin_q = wdata;
      ibmc_pkg::REG_FACING_INDEX:   facing_index_q = wdata[3:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(logic [18:0] limit_w, logic [18:0] margin_w,
                                logic [18:0] facing_w);
    drain();
    write_reg(ibmc_pkg::REG_OBSTACLE_LIMIT, limit_w);
    write_reg(ibmc_pkg::REG_PEAK_MARGIN, margin_w);
    write_reg(ibmc_pkg::REG_FACING_INDEX, facing_w);
    settings_used++;
  endtask

  // One window's worth of ticks shaped as low, raised, low light, ending on a bright sample.
  task automatic run_light_episode();
    sensor_tick_t t;
    int unsigned base, bump;
    bit blocked;
    base = $urandom_range(0, 20000);
    bump = $urandom_range(0, 25000);
    for (int k = 0; k < LIGHT_DEPTH; k++) begin
      if (k == 0) blocked = $urandom_range(0, 3) != 0;
      else if (k == LIGHT_DEPTH - 1) blocked = $urandom_range(0, 2) == 0;
      else blocked = $urandom_range(0, 24) == 0;
      t = random_tick(blocked);
      if (k == LIGHT_DEPTH - 1)
        t.light = 16'(base + bump + $urandom_range(0, 10000));
      else if (k >= LIGHT_DEPTH / 3 && k < 2 * (LIGHT_DEPTH / 3))
        t.light = 16'(base + bump + $urandom_range(0, 400));
      else
        t.light = 16'(base + $urandom_range(0, 400));
      send_tick(t);
    end
  endtask

  task automatic run_phase(int episodes, int noise);
    repeat (episodes) run_light_episode();
    repeat (noise) send_tick(random_tick($urandom_range(0, 5) == 0));
  endtask

  task automatic test_hit_then_leave();
    send_tick(make_tick(16'd1000, 16'd0, 16'hFFFF, 16'hFFFF, '0));
    send_tick(make_tick(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, '1));
    for (int k = 3; k <= 10; k++)
      send_tick(make_tick(16'd5000, 16'hFFFF, 16'hFFFF, 16'hFFFF, '1));
    for (int k = 11; k <= 19; k++)
      send_tick(make_tick(16'd0, 16'(200 + k), 16'd300, 16'hFFFF,
                          ir_pattern(k % ibmc_pkg::IR_COUNT, 16'hFFFF, 16'hFFFE)));
    // bright sample over a peak while blocked: leave wins, no hit
    send_tick(make_tick(16'd1001, 16'hFFFF, 16'd0, 16'hFFFF, {12{16'h00FF}}));
    send_tick(make_tick(16'd0, 16'hFFFF, 16'hFFFF, 16'd200, {12{16'h0F0F}}));
  endtask

  task automatic test_ir_selection();
    logic [191:0] readings;
    send_tick(make_tick(16'd77, 16'hFFFF, 16'hFFFF, 16'hFFFF, {12{16'h1234}}));
    readings = ir_pattern(9, 16'hC000, 16'h7FFF);
    readings[16*11 +: 16] = 16'hC000;
    send_tick(make_tick(16'd78, 16'hFFFF, 16'hFFFF, 16'hFFFF, readings));
    readings = ir_pattern(9, 16'hC000, 16'h7FFF);
    readings[16*3 +: 16] = 16'hC000;
    send_tick(make_tick(16'd79, 16'hFFFF, 16'hFFFF, 16'hFFFF, readings));
    send_tick(make_tick(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, '1));
  endtask

  task automatic test_register_extremes();
    apply_settings(19'd0, 19'd0, 19'd0);
    run_phase(1, 10);
    apply_settings(19'h0FFFF, 19'h7FFFF, 19'd11);
    run_phase(1, 10);
    apply_settings(19'($urandom_range(0, 65535)), 19'd0, 19'd15);
    run_phase(1, 10);
    apply_settings(19'h0FFFF, 19'd0, 19'd12);
    write_reg(REG_UNUSED_SLOT, '1);
    run_phase(1, 10);
  endtask

  task automatic test_random_episodes();
    int unsigned lim, margin, facing;
    repeat (8) begin
      lim = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 3000);
      margin = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 524287) : $urandom_range(0, 3000);
      facing = ($urandom_range(0, 7) == 0) ? $urandom_range(12, 15) : $urandom_range(0, 11);
      apply_settings({3'($urandom), 16'(lim)}, 19'(margin), {15'($urandom), 4'(facing)});
      run_phase(4, 12);
    end
  endtask

  task automatic test_back_to_back();
    apply_settings(19'($urandom_range(100, 2000)), 19'($urandom_range(0, 2000)),
                   19'($urandom_range(0, 11)));
    quiet_tail = 1'b1;
    run_phase(6, 20);
  endtask

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (quiet_tail || $urandom_range(0, 3) != 0) begin
        out_ready = 1'b1;
        repeat ($urandom_range(1, 20) - 1) @(negedge clk);
      end else begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 13) - 1) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result beat with nothing expected, expected none, got mode %0d",
                 $time, mode);
        error_count++;
      end else begin
        due_result = pending_results.pop_front();
        check_field("mode", due_result.mode, mode);
        check_field("peak_seen", due_result.peak, peak_seen);
        check_field("left_boundary", due_result.left, left_boundary);
        check_field("hit_obstacle", due_result.hit, hit_obstacle);
        results_checked++;
      end
    end
  end

  initial begin
    #4000000;
    $display("Timed out with %0d results outstanding", pending_results.size());
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_index = ibmc_pkg::REG_OBSTACLE_LIMIT;
    cfg_wdata = '0;
    in_valid = 1'b0;
    light_sample = '0;
    range_front = '0;
    range_front_left = '0;
    range_front_right = '0;
    ir_group_low = '0;
    ir_group_mid = '0;
    ir_group_high = '0;
    quiet_tail = 1'b0;
    error_count = 0;
    ticks_sent = 0;
    results_checked = 0;
    hits_predicted = 0;
    leaves_predicted = 0;
    peaks_predicted = 0;
    settings_used = 0;
    for (int i = 0; i < LIGHT_DEPTH; i++) light_history[i] = '0;
    tracking_boundary = 1'b0;
    stored_hit_level = '0;
    obstacle_limit_q = ibmc_pkg::OBSTACLE_LIMIT_RST;
    peak_margin_q = ibmc_pkg::PEAK_MARGIN_RST;
    facing_index_q = ibmc_pkg::FACING_INDEX_RST;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_hit_then_leave();
    test_ir_selection();
    test_register_extremes();
    test_random_episodes();
    test_back_to_back();

    drain();
    repeat (8) @(posedge clk);
    $display("Checked %0d result beats from %0d ticks over %0d register settings",
             results_checked, ticks_sent, settings_used);
    $display("Predicted %0d hits, %0d leaves and %0d window peaks",
             hits_predicted, leaves_predicted, peaks_predicted);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
